[hdl/assert_macros.svh]
// assertion helpers used by the engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define GLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition a implies condition b on the following edge
`define GLE_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[hdl/gle_pkg.sv]
// ----------------------------------------------------------------------------
// gle_pkg
// shared types and constants of the life generation engine
// ----------------------------------------------------------------------------
`default_nettype none
package gle_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int SIZE_W      = 7;
  localparam int MEM_AW      = ROW_W + 1;
  localparam int STEP_W      = $clog2(MAX_ROWS + 2);
  localparam int CNT_W       = 4;

  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_LOW = CNT_W'(2);

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_GEN,
    S_DRAIN
  } state_t;

  // vertical three-cell window of one column
  typedef struct packed {
    logic up;
    logic mid;
    logic lo;
  } col_t;

endpackage
`default_nettype wire

[hdl/gle_cell.sv]
// ----------------------------------------------------------------------------
// gle_cell
// one column cell: keeps two rows of its column and computes the next state
// ----------------------------------------------------------------------------
`default_nettype none
module gle_cell
  import gle_pkg::*;
(
  input  wire       clk,
  input  wire       shift,
  input  wire       lo_in,
  input  wire col_t left,
  input  wire col_t right,
  output col_t      win,
  output logic      next_alive
);

  logic up_r, mid_r;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (shift) begin
      up_r  <= mid_r;
      mid_r <= lo_in;
    end
  end

  assign win = '{up: up_r, mid: mid_r, lo: lo_in};

  always_comb begin
    cnt = CNT_W'(left.up) + CNT_W'(left.mid) + CNT_W'(left.lo)
        + CNT_W'(right.up) + CNT_W'(right.mid) + CNT_W'(right.lo)
        + CNT_W'(up_r) + CNT_W'(lo_in);
    next_alive = (cnt == BIRTH_COUNT) || (mid_r && (cnt == SURVIVE_LOW));
  end

endmodule
`default_nettype wire

[hdl/gle_grid_mem.sv]
// ----------------------------------------------------------------------------
// gle_grid_mem
// both grid banks as one row-wide memory, rows never written read as dead
// ----------------------------------------------------------------------------
`default_nettype none
module gle_grid_mem
  import gle_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    we_row,
  input  wire                    we_bit,
  input  wire [MEM_AW-1:0]       waddr,
  input  wire [MAX_COLUMNS-1:0]  wrow,
  input  wire [COL_W-1:0]        wcol,
  input  wire                    wbit,
  input  wire                    re,
  input  wire [MEM_AW-1:0]       raddr,
  output logic [MAX_COLUMNS-1:0] rdata
);

  localparam int DEPTH = 2 * MAX_ROWS;

  logic [MAX_COLUMNS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       valid_r;
  logic [MAX_COLUMNS-1:0] q_r;
  logic                   qv_r;

  always_ff @(posedge clk) begin
    if (we_row) begin
      mem[waddr] <= wrow;
    end else if (we_bit) begin
      if (valid_r[waddr]) begin
        mem[waddr][wcol] <= wbit;
      end else begin
        mem[waddr] <= MAX_COLUMNS'(wbit) << wcol;
      end
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      if (we_row || we_bit) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        qv_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = qv_r ? q_r : '0;

endmodule
`default_nettype wire

[hdl/toroidal_life_generation_engine.sv]
// ----------------------------------------------------------------------------
// toroidal_life_generation_engine
// b3/s23 game of life on a wrapped grid of up to 64 by 64 cells
// ----------------------------------------------------------------------------
// Each input beat writes one cell, reads one cell or advances the grid by one
// generation; every beat returns exactly one output beat. A read answers
// after its registered memory read, by way of S_RDWAIT. A generation walks a
// row of 64 column cells down the grid one row per cycle, fed by the single
// read port of the grid memory; all rows of the current bank are walked whatever
// the grid size in use, since rows beyond the grid are copied across unchanged.
// The two banks live in one memory; per-row valid bits clear it at reset, so
// no clearing pass is needed. Geometry registers sit at byte 0 (columns) and
// byte 4 (rows); 0 acts as 1 and values above 64 act as 64.
`default_nettype none
module toroidal_life_generation_engine
  import gle_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: req_type[1:0], cell_row[7:2], cell_col[13:8], cell_value[14]
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,
  // out_tdata: read_value[0], op_done[1]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "assert_macros.svh"

  localparam int LAST_STEP = MAX_ROWS + 1;

  // configuration
  logic [SIZE_W-1:0] cols_r, rows_r, nc, nr;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SIZE_W'(MAX_COLUMNS);
      rows_r <= SIZE_W'(MAX_ROWS);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_COLUMNS) begin
        cols_r <= cfg_pwdata[SIZE_W-1:0];
      end else begin
        rows_r <= cfg_pwdata[SIZE_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ROWS) ? 32'(rows_r) : 32'(cols_r);

  // effective geometry, clamped
  always_comb begin
    nc = (cols_r == '0) ? SIZE_W'(1) :
         (cols_r > SIZE_W'(MAX_COLUMNS)) ? SIZE_W'(MAX_COLUMNS) : cols_r;
    nr = (rows_r == '0) ? SIZE_W'(1) :
         (rows_r > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_r;
  end

  // input fields
  logic [1:0]       req_type;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_col;
  logic             cell_value;

  assign req_type   = in_tdata[1:0];
  assign cell_row   = in_tdata[7:2];
  assign cell_col   = in_tdata[13:8];
  assign cell_value = in_tdata[14];

  // control state
  state_t            st_r, st_nxt;
  logic              bank_r, bank_nxt;
  logic [STEP_W-1:0] k_r, k_nxt;      // read step being issued
  logic [STEP_W-1:0] dk_r;            // step whose data is on the read port
  logic              dv_r;
  logic [COL_W-1:0]  rcol_r, rcol_nxt;
  logic              ov_r, ov_nxt, ord_r, ord_nxt, odone_r, odone_nxt;

  // memory hookup
  logic                   we_row, we_bit, re;
  logic [MEM_AW-1:0]      waddr, raddr;
  logic [MAX_COLUMNS-1:0] wrow, rdata, new_row;
  logic                   acc, in_grid;
  logic [ROW_W-1:0]       step_row;

  assign in_tready = (st_r == S_IDLE) && (!ov_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign in_grid   = (SIZE_W'(cell_row) < nr) && (SIZE_W'(cell_col) < nc);

  // row read at step k: wrapped row above, the rows in use, row 0 again,
  // then the rows beyond the grid for copying
  always_comb begin
    if (k_r == '0) begin
      step_row = ROW_W'(nr - SIZE_W'(1));
    end else if (SIZE_W'(k_r) <= nr) begin
      step_row = ROW_W'(k_r - STEP_W'(1));
    end else if (SIZE_W'(k_r) == nr + SIZE_W'(1)) begin
      step_row = '0;
    end else begin
      step_row = ROW_W'(k_r - STEP_W'(2));
    end
  end

  always_comb begin
    st_nxt    = st_r;
    bank_nxt  = bank_r;
    k_nxt     = k_r;
    rcol_nxt  = rcol_r;
    ov_nxt    = ov_r && !out_tready;
    ord_nxt   = ord_r;
    odone_nxt = odone_r;
    we_bit    = 1'b0;
    re        = 1'b0;
    raddr     = {bank_r, cell_row};
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          case (req_type)
            REQ_WRITE: begin
              we_bit    = in_grid;
              ov_nxt    = 1'b1;
              ord_nxt   = 1'b0;
              odone_nxt = in_grid;
            end
            REQ_READ: begin
              if (in_grid) begin
                re       = 1'b1;
                rcol_nxt = cell_col;
                st_nxt   = S_RDWAIT;
              end else begin
                ov_nxt    = 1'b1;
                ord_nxt   = 1'b0;
                odone_nxt = 1'b0;
              end
            end
            REQ_ADVANCE: begin
              k_nxt  = '0;
              st_nxt = S_GEN;
            end
            default: begin
              ov_nxt    = 1'b1;
              ord_nxt   = 1'b0;
              odone_nxt = 1'b0;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        ov_nxt    = 1'b1;
        ord_nxt   = rdata[rcol_r];
        odone_nxt = 1'b1;
        st_nxt    = S_IDLE;
      end
      S_GEN: begin
        re    = 1'b1;
        raddr = {bank_r, step_row};
        k_nxt = k_r + STEP_W'(1);
        if (k_r == STEP_W'(LAST_STEP)) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        bank_nxt  = ~bank_r;
        ov_nxt    = 1'b1;
        ord_nxt   = 1'b0;
        odone_nxt = 1'b1;
        st_nxt    = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      bank_r  <= 1'b0;
      k_r     <= '0;
      dk_r    <= '0;
      dv_r    <= 1'b0;
      ov_r    <= 1'b0;
      ord_r   <= 1'b0;
      odone_r <= 1'b0;
      rcol_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      bank_r  <= bank_nxt;
      k_r     <= k_nxt;
      dk_r    <= k_r;
      dv_r    <= (st_r == S_GEN);
      ov_r    <= ov_nxt;
      ord_r   <= ord_nxt;
      odone_r <= odone_nxt;
      rcol_r  <= rcol_nxt;
    end
  end

  // new row goes to the other bank from step 2 on; rows in use are computed,
  // rows beyond are copied straight from the read port
  logic gen_row;
  assign gen_row = SIZE_W'(dk_r) <= nr + SIZE_W'(1);
  assign we_row  = dv_r && (dk_r >= STEP_W'(2));
  assign wrow    = gen_row ? new_row : rdata;
  assign waddr   = we_row ? {~bank_r, ROW_W'(dk_r - STEP_W'(2))} : {bank_r, cell_row};

  gle_grid_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .we_row (we_row),
    .we_bit (we_bit),
    .waddr  (waddr),
    .wrow   (wrow),
    .wcol   (cell_col),
    .wbit   (cell_value),
    .re     (re),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  // chain of column cells, wrapped at the column count in use
  col_t                   win [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] nxt;
  col_t                   wrap_left;

  assign wrap_left = win[COL_W'(nc - SIZE_W'(1))];

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_cell
    col_t lft, rgt;
    if (c == 0) begin : g_first
      assign lft = wrap_left;
    end else begin : g_inner
      assign lft = win[c-1];
    end
    if (c == MAX_COLUMNS - 1) begin : g_last
      assign rgt = win[0];
    end else begin : g_mid
      assign rgt = (SIZE_W'(c) == nc - SIZE_W'(1)) ? win[0] : win[c+1];
    end

    gle_cell u_cell (
      .clk        (clk),
      .shift      (dv_r),
      .lo_in      (rdata[c]),
      .left       (lft),
      .right      (rgt),
      .win        (win[c]),
      .next_alive (nxt[c])
    );

    // columns beyond the grid keep their value
    assign new_row[c] = (SIZE_W'(c) < nc) ? nxt[c] : win[c].mid;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'b0, odone_r, ord_r};

  // no input taken while a generation runs
  `GLE_ASSERT(a_busy_no_accept, (st_r == S_GEN || st_r == S_DRAIN) |-> !in_tready)
  // a finished generation flips the current bank
  `GLE_ASSERT_NEXT(a_bank_flip, st_r == S_DRAIN, bank_r != $past(bank_r))
  // a read value only comes with a completed operation
  `GLE_ASSERT(a_read_done, out_tvalid |-> !(ord_r && !odone_r))

endmodule
`default_nettype wire

[dv/life_checker.sv]
// ----------------------------------------------------------------------------
// life_checker
// watches the request and response streams, keeps a shadow of both grid
// banks and compares every response beat with the predicted one
// ----------------------------------------------------------------------------
module life_checker
  import gle_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [15:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [7:0]  out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire         cfg_pready,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count,
  output int          read_count,
  output int          gen_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;

  typedef struct packed {
    logic read_value;
    logic op_done;
  } resp_t;

  logic [CELLS-1:0] shadow_bank [2];
  logic             live_bank;
  logic [6:0]       cols_reg;
  logic [6:0]       rows_reg;
  resp_t            resp_queue [$];

  function automatic int in_use(logic [6:0] r, int maxv);
    if (r == 0) return 1;
    return (r > maxv) ? maxv : int'(r);
  endfunction

  // one generation of b3/s23 with wrap at the in-use size
  task automatic step_generation();
    int nc;
    int nr;
    int n;
    logic [CELLS-1:0] src;
    logic [CELLS-1:0] dst;
    nc  = in_use(cols_reg, MAX_COLUMNS);
    nr  = in_use(rows_reg, MAX_ROWS);
    src = shadow_bank[live_bank];
    dst = src;  // cells outside the grid carry over
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += src[((r + nr + dr) % nr) * MAX_COLUMNS + (c + nc + dc) % nc];
            end
          end
        end
        dst[r * MAX_COLUMNS + c] = src[r * MAX_COLUMNS + c] ?
                                   (n == SURVIVE_LOW || n == BIRTH_COUNT) :
                                   (n == BIRTH_COUNT);
      end
    end
    shadow_bank[!live_bank] = dst;
    live_bank = !live_bank;
  endtask

  task automatic predict_request(logic [15:0] d);
    logic [1:0] kind;
    int         row;
    int         col;
    resp_t      rsp;
    kind = d[1:0];
    row  = d[7:2];
    col  = d[13:8];
    rsp  = '0;
    if (kind == REQ_WRITE || kind == REQ_READ) begin
      if (row < in_use(rows_reg, MAX_ROWS) && col < in_use(cols_reg, MAX_COLUMNS)) begin
        if (kind == REQ_WRITE) shadow_bank[live_bank][row * MAX_COLUMNS + col] = d[14];
        else begin
          rsp.read_value = shadow_bank[live_bank][row * MAX_COLUMNS + col];
          read_count++;
        end
        rsp.op_done = 1'b1;
      end
    end else if (kind == REQ_ADVANCE) begin
      step_generation();
      gen_count++;
      rsp.op_done = 1'b1;
    end
    resp_queue.push_back(rsp);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_bank[0] = '0;
      shadow_bank[1] = '0;
      live_bank      = 1'b0;
      cols_reg       = 7'd64;
      rows_reg       = 7'd64;
      resp_queue.delete();
      fail_count     = 0;
      read_count     = 0;
      gen_count      = 0;
      pending_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_COLUMNS) cols_reg = cfg_pwdata[6:0];
        else                             rows_reg = cfg_pwdata[6:0];
      end
      if (out_tvalid && out_tready) begin
        if (resp_queue.size() == 0) begin
          $display("%0t: unexpected response beat %h", $time, out_tdata);
          fail_count++;
        end else begin
          resp_t exp_rsp;
          exp_rsp = resp_queue.pop_front();
          if (out_tdata[0] !== exp_rsp.read_value) begin
            $display("%0t: read_value expected %0d actual %0d", $time,
                     exp_rsp.read_value, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[1] !== exp_rsp.op_done) begin
            $display("%0t: op_done expected %0d actual %0d", $time,
                     exp_rsp.op_done, out_tdata[1]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tdata);
      pending_count <= resp_queue.size();
    end
  end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// stimulus for the life generation engine: directed cell and glider cases
// over several grid geometries, then random request mixes, most with gaps
// ----------------------------------------------------------------------------
module tb
  import gle_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;  // req_type, cell_row, cell_col, cell_value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;     // read_value, op_done
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending_count;
  int read_count;
  int gen_count;
  int cycle_count = 0;
  int beat_count = 0;
  int idle_bias = 0;  // 0 means no gaps on either side
  int stall_left = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  toroidal_life_generation_engine dut (.*);

  life_checker checker_i (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    if (idle_bias == 0) return 0;
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // result side stalls at random, now and then for a long stretch
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (idle_bias == 0) out_tready <= 1'b1;
    else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(49) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(30);
    end else out_tready <= ($urandom_range(9) < 7);
  end

  // valid stays up after the beat so a following beat can go back to back
  task automatic send_beat(logic [1:0] kind, logic [5:0] row, logic [5:0] col, logic v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, v, col, row, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beat_count++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);  // covers a whole generation pass
  endtask

  task automatic write_geometry(logic addr_sel, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {addr_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [31:0] cols, logic [31:0] rows);
    wait_idle();
    write_geometry(REG_COLUMNS, cols);
    write_geometry(REG_ROWS, rows);
  endtask

  // writes as the largest share, within rows 0 to span_r and columns 0 to span_c, so patterns evolve
  task automatic random_phase(int count, int span_r, int span_c);
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < 45)
        send_beat(REQ_WRITE, 6'($urandom_range(span_r)), 6'($urandom_range(span_c)),
                  1'($urandom_range(1)));
      else if (p < 75)
        send_beat(REQ_READ, 6'($urandom_range(span_r)), 6'($urandom_range(span_c)), 1'b0);
      else if (p < 90)
        send_beat(REQ_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom));
      else
        send_beat(2'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
      if (i == count / 2) wait_idle();  // sender holds off until all results are back
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners of the full grid, unused request code, glider at the wrapped corner
    send_beat(REQ_WRITE, 6'd63, 6'd63, 1'b1);
    send_beat(REQ_READ,  6'd63, 6'd63, 1'b0);
    send_beat(REQ_READ,  6'd0,  6'd0,  1'b0);
    send_beat(2'd3,      6'd63, 6'd63, 1'b1);
    send_beat(REQ_WRITE, 6'd0,  6'd1,  1'b1);
    send_beat(REQ_WRITE, 6'd1,  6'd2,  1'b1);
    send_beat(REQ_WRITE, 6'd2,  6'd0,  1'b1);
    send_beat(REQ_WRITE, 6'd2,  6'd1,  1'b1);
    send_beat(REQ_WRITE, 6'd2,  6'd2,  1'b1);
    send_beat(REQ_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_beat(REQ_READ,  6'd63, 6'd63, 1'b0);
    send_beat(REQ_READ,  6'd3,  6'd1,  1'b0);
    send_beat(REQ_WRITE, 6'd63, 6'd63, 1'b0);

    // tiny grid: single cell counts itself eight times; out of range cells ignored
    set_grid(1, 0);
    send_beat(REQ_WRITE, 6'd0, 6'd0, 1'b1);
    send_beat(REQ_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_beat(REQ_READ,  6'd0, 6'd0, 1'b0);
    send_beat(REQ_READ,  6'd0, 6'd1, 1'b0);
    send_beat(REQ_WRITE, 6'd1, 6'd0, 1'b1);

    // two by two, then oversize values clamp to 64
    set_grid(2, 2);
    send_beat(REQ_WRITE, 6'd1, 6'd1, 1'b1);
    send_beat(REQ_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_beat(REQ_READ,  6'd1, 6'd1, 1'b0);
    set_grid(127, 100);
    send_beat(REQ_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_beat(REQ_READ,  6'd2, 6'd1, 1'b0);

    // random phases over several geometries, all but the last with gaps
    idle_bias = 1;
    set_grid(5, 4);
    random_phase(30, 5, 6);
    set_grid(64, 64);
    random_phase(30, 63, 63);
    set_grid(3, 7);
    random_phase(30, 8, 4);
    idle_bias = 0;
    set_grid(13, 1);
    random_phase(30, 2, 15);

    wait_idle();
    $display("sent %0d request beats: %0d cell reads and %0d generations checked",
             beat_count, read_count, gen_count);
    $display("geometries covered 1x1 up to 64x64, including clamped register values");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
